// File: design/sed_pkg.sv
// ----------------------------------------------------------------------------
// Sobel edge detection package
// Shared constants, register codes and item types of the Sobel edge detector.
// ----------------------------------------------------------------------------
package sed_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  // Column and row counters, and the width of the frame-size registers.
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int DIM_W = 11;

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_e;

  // Luma weights; the weighted sum is divided by 1000 through a reciprocal.
  // The shift is wide enough that the rounded-up reciprocal never carries a
  // sum just below a multiple of 1000 over to the next quotient.
  localparam int COEF_R     = 299;
  localparam int COEF_G     = 587;
  localparam int COEF_B     = 114;
  localparam int LUMA_SUM_W = 18;
  localparam int LUMA_SHIFT = 28;
  localparam int LUMA_RECIP = (1 << LUMA_SHIFT) / 1000 + 1;
  localparam int RECIP_W    = 19;

  localparam int PIX_W  = 8;
  localparam int LINE_W = 2 * PIX_W;

  localparam logic [PIX_W-1:0] LEVEL_MAX = 8'd255;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_red;
    logic [PIX_W-1:0] pixel_green;
    logic [PIX_W-1:0] pixel_blue;
    logic             drain;
  } pix_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] edge_level;
    logic             opaque;
    logic             frame_end;
  } pix_out_t;

endpackage

// File: design/sed_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Simple dual-port memory, one write and one registered read port, read-first.
// ----------------------------------------------------------------------------
module sed_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/sobel_edge_detection_top.sv
// ----------------------------------------------------------------------------
// Sobel edge detector, top level
// Streaming 3x3 Sobel filter on the luma of an RGB pixel stream.
// ----------------------------------------------------------------------------
// Input items arrive on in_valid_i/in_ready_o in raster order; an item with
// drain set carries no pixel and only pushes out one pending result. Result
// items leave on out_valid_o/out_ready_i in raster order, lagging the pixels
// by image_width+1 positions; border positions come out with a zero level and
// opaque clear. Throughput is one item per cycle unless the output stalls.
// Stages: input register; luma products into stage 2; reciprocal multiply and
// line-store update into the window and stage 3; gradient into the output
// register. The line stores sit in one 16-bit RAM; recent writes are forwarded
// so that narrow rows read current data. Reset sets the frame to 640 x 480
// and empties the pipeline; the line stores read as zero until written,
// tracked by a fill count, so no clearing pass is needed. Writing a size
// register restarts the frame position. When the receiver stalls, the output
// register holds its item and the three inner stages keep filling, so
// in_ready_o falls only once all of them are full.
// ----------------------------------------------------------------------------
module sobel_edge_detection_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  sed_pkg::pix_in_t               in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output sed_pkg::pix_out_t              out_item_o,
  input  logic                           cfg_we_i,
  input  logic [sed_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sed_pkg::DIM_W-1:0]      cfg_data_i
);
  import sed_pkg::*;

  typedef struct packed {
    logic emit;
    logic inner;
    logic last;
  } out_ctrl_t;

  typedef struct packed {
    logic              valid;
    logic [COL_W-1:0]  addr;
    logic [LINE_W-1:0] data;
  } line_wr_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] lim);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > lim) begin
      r = lim;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Frame size, held already clamped.
  logic [DIM_W-1:0] width_q, height_q;

  // Position and pending state, updated when an item is accepted; the fill count on line writes.
  logic [COL_W-1:0] in_col_q, in_col_d;
  logic [ROW_W-1:0] in_row_q, in_row_d;
  logic [DIM_W-1:0] pend_q, pend_d;
  logic [COL_W-1:0] out_col_q, out_col_d;
  logic [ROW_W-1:0] out_row_q, out_row_d;
  logic [DIM_W-1:0] fill_q;

  // Pipeline stages.
  logic             v1_q, v2_q, v3_q;
  logic [PIX_W-1:0] r1_q, g1_q, b1_q;
  logic             drain1_q, drain2_q;
  logic [COL_W-1:0] addr1_q, addr2_q;
  logic             fresh1_q, fresh2_q;
  out_ctrl_t        ctl1_q, ctl2_q, ctl3_q, ctl_d;
  logic [LUMA_SUM_W-1:0] sum2_q, sum2_d;
  logic [LINE_W-1:0] line2_q;
  line_wr_t         hist0_q, hist1_q;
  logic [PIX_W-1:0] win_q [9];
  logic             out_valid_q;
  pix_out_t         out_item_q;

  logic accept, is_pixel, emit;
  logic out_free, s3_go, rdy3, s2_go, rdy2, s1_go, rdy1;

  logic [DIM_W-1:0] in_col_inc, in_row_inc, out_col_inc, out_row_inc, pend_inc;
  logic [DIM_W-1:0] out_col_x, out_row_x;

  logic [LINE_W-1:0] ram_rdata;
  logic [LINE_W-1:0] line_cur;
  logic [PIX_W-1:0]  upper_val, middle_val, luma;
  logic [LUMA_SUM_W+RECIP_W-1:0] luma_prod;
  logic              line_we;

  logic [9:0]  gx_pos, gx_neg, gy_pos, gy_neg;
  logic [10:0] gx, gy;
  logic [9:0]  gx_abs, gy_abs;
  logic [10:0] mag_sum;
  logic [PIX_W-1:0] mag;

  // Handshake and stage advance.
  assign out_free = !out_valid_q || out_ready_i;
  assign s3_go    = v3_q && (!ctl3_q.emit || out_free);
  assign rdy3     = !v3_q || s3_go;
  assign s2_go    = v2_q && rdy3;
  assign rdy2     = !v2_q || rdy3;
  assign s1_go    = v1_q && rdy2;
  assign rdy1     = !v1_q || rdy2;

  assign in_ready_o = rdy1;
  assign accept     = in_valid_i && rdy1;
  assign is_pixel   = !in_item_i.drain;

  // Position bookkeeping at acceptance.
  always_comb begin
    in_col_inc  = DIM_W'(in_col_q) + DIM_W'(1);
    in_row_inc  = DIM_W'(in_row_q) + DIM_W'(1);
    out_col_inc = DIM_W'(out_col_q) + DIM_W'(1);
    out_row_inc = DIM_W'(out_row_q) + DIM_W'(1);
    out_col_x   = DIM_W'(out_col_q);
    out_row_x   = DIM_W'(out_row_q);
    pend_inc    = pend_q + DIM_W'(1);

    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;

    if (is_pixel) begin
      emit = pend_inc >= (width_q + DIM_W'(1));
      pend_d = emit ? pend_q : pend_inc;
      if (in_col_inc >= width_q) begin
        in_col_d = '0;
        in_row_d = (in_row_inc >= height_q) ? '0 : in_row_inc[ROW_W-1:0];
      end else begin
        in_col_d = in_col_inc[COL_W-1:0];
      end
    end else begin
      emit = pend_q != '0;
      pend_d = emit ? pend_q - DIM_W'(1) : pend_q;
    end

    ctl_d.emit  = emit;
    ctl_d.inner = (out_col_x >= DIM_W'(1)) && (out_col_x + DIM_W'(2) <= width_q) &&
                  (out_row_x >= DIM_W'(1)) && (out_row_x + DIM_W'(2) <= height_q);
    ctl_d.last  = (out_col_inc >= width_q) && (out_row_inc >= height_q);

    if (emit) begin
      if (out_col_inc >= width_q) begin
        out_col_d = '0;
        out_row_d = (out_row_inc >= height_q) ? '0 : out_row_inc[ROW_W-1:0];
      end else begin
        out_col_d = out_col_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= DIM_W'(640);
      height_q  <= DIM_W'(480);
      in_col_q  <= '0;
      in_row_q  <= '0;
      pend_q    <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_IMAGE_WIDTH: begin
          width_q   <= clamp_dim(cfg_data_i, DIM_W'(MAX_WIDTH));
          in_col_q  <= '0;
          in_row_q  <= '0;
          pend_q    <= '0;
          out_col_q <= '0;
          out_row_q <= '0;
        end
        REG_IMAGE_HEIGHT: begin
          height_q  <= clamp_dim(cfg_data_i, DIM_W'(MAX_HEIGHT));
          in_col_q  <= '0;
          in_row_q  <= '0;
          pend_q    <= '0;
          out_col_q <= '0;
          out_row_q <= '0;
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      pend_q    <= pend_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

  // Line stores: upper row in the high byte, middle row in the low byte.
  sed_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (addr2_q),
    .wdata_i ({middle_val, luma}),
    .re_i    (accept),
    .raddr_i (in_col_q),
    .rdata_o (ram_rdata)
  );

  // Stage 1: input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (rdy1) begin
      v1_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      r1_q     <= in_item_i.pixel_red;
      g1_q     <= in_item_i.pixel_green;
      b1_q     <= in_item_i.pixel_blue;
      drain1_q <= in_item_i.drain;
      addr1_q  <= in_col_q;
      // An entry at or beyond the fill count has never been written.
      fresh1_q <= DIM_W'(in_col_q) >= fill_q;
      ctl1_q   <= ctl_d;
    end
  end

  assign sum2_d = LUMA_SUM_W'(r1_q) * LUMA_SUM_W'(COEF_R)
                + LUMA_SUM_W'(g1_q) * LUMA_SUM_W'(COEF_G)
                + LUMA_SUM_W'(b1_q) * LUMA_SUM_W'(COEF_B);

  // Stage 2: luma division, line-store update and window shift.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (rdy2) begin
      v2_q <= s1_go;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      sum2_q   <= sum2_d;
      drain2_q <= drain1_q;
      addr2_q  <= addr1_q;
      fresh2_q <= fresh1_q;
      line2_q  <= ram_rdata;
      ctl2_q   <= ctl1_q;
    end
  end

  // Writes that landed after this item's read are at most the two most recent
  // ones, so a two-entry history is enough to see current line data.
  always_comb begin
    if (hist0_q.valid && hist0_q.addr == addr2_q) begin
      line_cur = hist0_q.data;
    end else if (hist1_q.valid && hist1_q.addr == addr2_q) begin
      line_cur = hist1_q.data;
    end else if (fresh2_q) begin
      line_cur = '0;
    end else begin
      line_cur = line2_q;
    end
  end

  assign upper_val  = line_cur[LINE_W-1:PIX_W];
  assign middle_val = line_cur[PIX_W-1:0];
  assign luma_prod  = (LUMA_SUM_W+RECIP_W)'(sum2_q) * (LUMA_SUM_W+RECIP_W)'(LUMA_RECIP);
  assign luma       = luma_prod[LUMA_SHIFT +: PIX_W];
  assign line_we    = s2_go && !drain2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist0_q <= '0;
      hist1_q <= '0;
      fill_q  <= '0;
    end else if (line_we) begin
      hist1_q       <= hist0_q;
      hist0_q.valid <= 1'b1;
      hist0_q.addr  <= addr2_q;
      hist0_q.data  <= {middle_val, luma};
      if (DIM_W'(addr2_q) >= fill_q) begin
        fill_q <= DIM_W'(addr2_q) + DIM_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 9; k++) begin
        win_q[k] <= '0;
      end
    end else if (line_we) begin
      for (int k = 0; k < 3; k++) begin
        win_q[k*3]     <= win_q[k*3 + 1];
        win_q[k*3 + 1] <= win_q[k*3 + 2];
      end
      win_q[2] <= upper_val;
      win_q[5] <= middle_val;
      win_q[8] <= luma;
    end
  end

  // Stage 3: gradient magnitude of the window as this item left it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (rdy3) begin
      v3_q <= s2_go;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_go) begin
      ctl3_q <= ctl2_q;
    end
  end

  always_comb begin
    gx_pos = 10'(win_q[2]) + {1'b0, win_q[5], 1'b0} + 10'(win_q[8]);
    gx_neg = 10'(win_q[0]) + {1'b0, win_q[3], 1'b0} + 10'(win_q[6]);
    gy_pos = 10'(win_q[6]) + {1'b0, win_q[7], 1'b0} + 10'(win_q[8]);
    gy_neg = 10'(win_q[0]) + {1'b0, win_q[1], 1'b0} + 10'(win_q[2]);
    gx     = {1'b0, gx_pos} - {1'b0, gx_neg};
    gy     = {1'b0, gy_pos} - {1'b0, gy_neg};
    gx_abs = gx[10] ? 10'(-gx) : gx[9:0];
    gy_abs = gy[10] ? 10'(-gy) : gy[9:0];
    mag_sum = 11'(gx_abs) + 11'(gy_abs);
    mag     = (mag_sum > 11'(LEVEL_MAX)) ? LEVEL_MAX : mag_sum[PIX_W-1:0];
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s3_go && ctl3_q.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_go && ctl3_q.emit) begin
      out_item_q.edge_level <= ctl3_q.inner ? mag : '0;
      out_item_q.opaque     <= ctl3_q.inner;
      out_item_q.frame_end  <= ctl3_q.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef SYNTH
  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= width_q)
    else $error("pending count exceeds the row width");

  a_in_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (DIM_W'(in_col_q) < width_q) && (DIM_W'(in_row_q) < height_q))
    else $error("input position outside the frame");

  a_out_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (DIM_W'(out_col_q) < width_q) && (DIM_W'(out_row_q) < height_q))
    else $error("output position outside the frame");

  a_emit_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && ctl3_q.emit && out_valid_q && !out_ready_i) |=> v3_q && ctl3_q.emit)
    else $error("a result item was dropped behind a stalled output");
`endif

endmodule

// File: bench/sobel_edge_detection_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel edge detector testbench
// Drives RGB pixel items and drain items into the edge detector under random
// sender gaps and receiver stalls, predicts every result item from its own
// model of the line stores, window and frame counters, and checks each result
// field by field in arrival order across several frame geometries.
// ----------------------------------------------------------------------------
module sobel_edge_detection_top_tb;
  import sed_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 820;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT = 400000;

  // Indexes that decode to no register.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_BLOCKED
  } rx_mode_e;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  pix_in_t              in_item = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  pix_out_t             out_item;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [DIM_W-1:0]     cfg_data = '0;

  sobel_edge_detection_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Edge predictor state
  // --------------------------------------------------------------------------
  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;
  logic [PIX_W-1:0] upper_row [0:MAX_WIDTH-1];
  logic [PIX_W-1:0] middle_row [0:MAX_WIDTH-1];
  logic [PIX_W-1:0] luma_win [0:8];
  int unsigned      in_col, in_row, results_owed, out_col, out_row;

  pix_out_t    pending_edges [$];
  int unsigned errors = 0;
  int unsigned accepted_items = 0;
  int unsigned burst_left = 0;

  function automatic int unsigned active_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return width_reg;
  endfunction

  function automatic int unsigned active_height();
    if (height_reg == 0) return 1;
    if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
    return height_reg;
  endfunction

  function automatic void restart_frame();
    in_col = 0;
    in_row = 0;
    results_owed = 0;
    out_col = 0;
    out_row = 0;
  endfunction

  function automatic void reset_predictor();
    width_reg = 11'd640;
    height_reg = 11'd480;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      upper_row[i] = '0;
      middle_row[i] = '0;
    end
    for (int i = 0; i < 9; i++) luma_win[i] = '0;
    restart_frame();
  endfunction

  function automatic int unsigned gradient_level();
    int gx, gy, mag;
    gx = (int'(luma_win[2]) + 2 * int'(luma_win[5]) + int'(luma_win[8]))
       - (int'(luma_win[0]) + 2 * int'(luma_win[3]) + int'(luma_win[6]));
    gy = (int'(luma_win[6]) + 2 * int'(luma_win[7]) + int'(luma_win[8]))
       - (int'(luma_win[0]) + 2 * int'(luma_win[1]) + int'(luma_win[2]));
    if (gx < 0) gx = -gx;
    if (gy < 0) gy = -gy;
    mag = gx + gy;
    if (mag > 255) mag = 255;
    return mag;
  endfunction

  // Queues the result for the oldest owed position and advances it.
  function automatic void release_edge_item();
    int unsigned w, h;
    bit          inner, last;
    pix_out_t    res;
    w = active_width();
    h = active_height();
    inner = out_col >= 1 && out_col + 2 <= w && out_row >= 1 && out_row + 2 <= h;
    last = (out_col + 1 >= w) && (out_row + 1 >= h);
    res.edge_level = inner ? PIX_W'(gradient_level()) : '0;
    res.opaque = inner;
    res.frame_end = last;
    pending_edges.push_back(res);
    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_row++;
      if (out_row >= h) out_row = 0;
    end
    if (results_owed > 0) results_owed--;
  endfunction

  function automatic void predict_edge_item(pix_in_t item);
    int unsigned      w, h, weighted, x;
    logic [PIX_W-1:0] luma;
    w = active_width();
    h = active_height();
    if (item.drain) begin
      if (results_owed != 0) release_edge_item();
      return;
    end
    weighted = item.pixel_red * COEF_R + item.pixel_green * COEF_G
             + item.pixel_blue * COEF_B;
    luma = PIX_W'(weighted / 1000);
    x = in_col;
    for (int k = 0; k < 3; k++) begin
      luma_win[k * 3] = luma_win[k * 3 + 1];
      luma_win[k * 3 + 1] = luma_win[k * 3 + 2];
    end
    luma_win[2] = upper_row[x];
    luma_win[5] = middle_row[x];
    luma_win[8] = luma;
    upper_row[x] = middle_row[x];
    middle_row[x] = luma;
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
      if (in_row >= h) in_row = 0;
    end
    results_owed++;
    if (results_owed >= w + 1) release_edge_item();
  endfunction

  // --------------------------------------------------------------------------
  // Item helpers
  // --------------------------------------------------------------------------
  function automatic logic [PIX_W-1:0] random_channel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom());
    endcase
  endfunction

  function automatic pix_in_t make_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                                         logic [PIX_W-1:0] b);
    pix_in_t item;
    item.pixel_red = r;
    item.pixel_green = g;
    item.pixel_blue = b;
    item.drain = 1'b0;
    return item;
  endfunction

  function automatic pix_in_t random_pixel();
    return make_pixel(random_channel(), random_channel(), random_channel());
  endfunction

  // The colour fields of a drain item carry noise; the block ignores them.
  function automatic pix_in_t drain_item();
    pix_in_t item;
    item = random_pixel();
    item.drain = 1'b1;
    return item;
  endfunction

  // Sends one item in bursts of random length separated by random gaps.
  task automatic send_item(input pix_in_t item);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid <= 1'b1;
    in_item <= item;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    burst_left--;
    accepted_items++;
    predict_edge_item(item);
  endtask

  // Holds the sender off until every predicted result item has arrived and the
  // pipeline has had time to retire items that release nothing.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_edges.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) begin
      width_reg = data;
      restart_frame();
    end else if (idx == REG_IMAGE_HEIGHT) begin
      height_reg = data;
      restart_frame();
    end
    @(posedge clk_i);
  endtask

  task automatic set_geometry(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    wait_for_results();
    cfg_write(REG_IMAGE_WIDTH, w);
    cfg_write(REG_IMAGE_HEIGHT, h);
  endtask

  // Pushes out every owed result, then one drain item with nothing owed.
  task automatic flush_owed();
    while (results_owed != 0) send_item(drain_item());
    send_item(drain_item());
  endtask

  task automatic send_pixels(input int unsigned count);
    repeat (count) send_item(random_pixel());
  endtask

  // --------------------------------------------------------------------------
  // Result checker and receiver stalls
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    pix_out_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (pending_edges.size() == 0) begin
        $error("unexpected result item: edge_level %0d opaque %0b frame_end %0b",
               out_item.edge_level, out_item.opaque, out_item.frame_end);
        errors++;
      end else begin
        want = pending_edges.pop_front();
        if (out_item.edge_level !== want.edge_level) begin
          $error("edge_level: expected %0d, actual %0d", want.edge_level, out_item.edge_level);
          errors++;
        end
        if (out_item.opaque !== want.opaque) begin
          $error("opaque: expected %0b, actual %0b", want.opaque, out_item.opaque);
          errors++;
        end
        if (out_item.frame_end !== want.frame_end) begin
          $error("frame_end: expected %0b, actual %0b", want.frame_end, out_item.frame_end);
          errors++;
        end
      end
    end
  end

  rx_mode_e    rx_mode = RX_OPEN;
  int unsigned rx_left = 0;

  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(8, 120);
    end
    rx_left--;
    case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
      default:   out_ready <= (rx_left % 16) < 4;
    endcase
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // The reset geometry is 640 x 480, so results only start after 641 pixels.
  task automatic test_reset_geometry();
    send_pixels(645);
    repeat (5) send_item(drain_item());
  endtask

  // Vertical black-to-white edge that saturates, then the primary colours and
  // white in the last row, and a drain with nothing owed.
  task automatic test_directed_extremes();
    set_geometry(11'd4, 11'd4);
    send_item(drain_item());
    for (int row = 0; row < 3; row++) begin
      send_item(make_pixel('0, '0, '0));
      send_item(make_pixel('0, '0, '0));
      send_item(make_pixel('1, '1, '1));
      send_item(make_pixel('1, '1, '1));
    end
    send_item(make_pixel('1, '0, '0));
    send_item(make_pixel('0, '1, '0));
    send_item(make_pixel('0, '0, '1));
    send_item(make_pixel('1, '1, '1));
    flush_owed();
  endtask

  // Zero acts as one.
  task automatic test_size_clamp();
    set_geometry('0, '0);
    send_pixels(10);
    flush_owed();
  endtask

  // Writes to undecoded indexes must not restart the frame.
  task automatic test_spare_index();
    set_geometry(11'd5, 11'd4);
    send_pixels(7);
    wait_for_results();
    cfg_write(REG_SPARE_LO, DIM_W'($urandom()));
    cfg_write(REG_SPARE_HI, DIM_W'($urandom()));
    send_pixels(20);
    flush_owed();
  endtask

  task automatic test_random_frames();
    int unsigned      start, len, w_eff, h_eff;
    logic [DIM_W-1:0] wv, hv;
    bit               paused;
    start = accepted_items;
    paused = 1'b0;
    while (accepted_items - start < RANDOM_ITEMS) begin
      wait_for_results();
      case ($urandom_range(0, 9))
        0: wv = '0;
        1: wv = DIM_W'($urandom_range(1, 2));
        2: wv = DIM_W'($urandom_range(17, 64));
        default: wv = DIM_W'($urandom_range(3, 16));
      endcase
      case ($urandom_range(0, 7))
        0: hv = DIM_W'($urandom_range(0, 2));
        1: hv = DIM_W'($urandom());
        default: hv = DIM_W'($urandom_range(3, 10));
      endcase
      case ($urandom_range(0, 4))
        0: cfg_write(REG_IMAGE_WIDTH, wv);
        1: cfg_write(REG_IMAGE_HEIGHT, hv);
        2: begin
          cfg_write(REG_IMAGE_HEIGHT, hv);
          cfg_write(REG_IMAGE_WIDTH, wv);
        end
        default: begin
          cfg_write(REG_IMAGE_WIDTH, wv);
          cfg_write(REG_IMAGE_HEIGHT, hv);
        end
      endcase
      w_eff = active_width();
      h_eff = active_height();
      // Mostly whole frames, several back to back, often cut short mid-row.
      len = $urandom_range(1, 3) * w_eff * h_eff + $urandom_range(0, w_eff);
      if (len > 240) len = $urandom_range(120, 240);
      for (int unsigned n = 0; n < len; n++) begin
        if ($urandom_range(0, 9) == 0) send_item(drain_item());
        else send_item(random_pixel());
        if (n == len / 2 && (!paused || $urandom_range(0, 7) == 0)) begin
          wait_for_results();
          paused = 1'b1;
        end
      end
      if ($urandom_range(0, 5) != 0) flush_owed();
    end
  endtask

  initial begin
    reset_predictor();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_geometry();
    test_directed_extremes();
    test_size_clamp();
    test_spare_index();
    test_random_frames();
    wait_for_results();
    if (errors == 0 && pending_edges.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

endmodule
